FILE: sv/png_unf_pkg.sv
`default_nettype none

package png_unf_pkg;

    localparam int PNGU_MAX_ROW_BYTES   = 8192;
    localparam int PNGU_MAX_PIXEL_BYTES = 8;

    localparam int BYTE_W      = 8;
    localparam int BPP_W       = 4;
    localparam int ROW_BYTES_W = 14;
    localparam int ROW_COUNT_W = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_BYTES_PER_PIXEL = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_BYTES       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT       = 2'd2;

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filter_kind_t;

    // Paeth predictor: pick whichever of a, b, c is nearest a + b - c, ties to a then b
    function automatic logic [BYTE_W-1:0] paeth_pick(
        input logic [BYTE_W-1:0] a,
        input logic [BYTE_W-1:0] b,
        input logic [BYTE_W-1:0] c
    );
        logic signed [9:0] pa_s;
        logic signed [9:0] pb_s;
        logic signed [9:0] pc_s;
        logic [9:0]        pa;
        logic [9:0]        pb;
        logic [9:0]        pc;
        logic [BYTE_W-1:0] pick;
        pa_s = $signed({2'b00, b}) - $signed({2'b00, c});
        pb_s = $signed({2'b00, a}) - $signed({2'b00, c});
        pc_s = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
        pa   = (pa_s < 0) ? 10'(-pa_s) : 10'(pa_s);
        pb   = (pb_s < 0) ? 10'(-pb_s) : 10'(pb_s);
        pc   = (pc_s < 0) ? 10'(-pc_s) : 10'(pc_s);
        if (pa <= pb && pa <= pc)
            pick = a;
        else if (pb <= pc)
            pick = b;
        else
            pick = c;
        return pick;
    endfunction

endpackage

`default_nettype wire

FILE: sv/png_unf_ram.sv
`default_nettype none

module png_unf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/png_scanline_unfilter_core.sv
// Channel   Direction  Handshake                Word
// --------  ---------  -----------------------  -------------------------------------------
// input     in         in_valid / in_stall      data_byte
// output    out        out_valid / out_stall    pixel_byte, row_end, image_end, bad_filter
// config    in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One byte per clock sustained while the output is not stalled. A data byte reads the line
// store as it is taken, is reconstructed the next cycle and written back as it moves to
// the output register. Filter-type bytes are absorbed at once.
// Reset is asynchronous; the line store is not cleared (row 0 ignores what it reads).
// A stalled output holds the compute stage, which then stalls the input.
`default_nettype none

module png_scanline_unfilter_core
    import png_unf_pkg::*;
#(
    parameter int MAX_ROW_BYTES   = PNGU_MAX_ROW_BYTES,
    parameter int MAX_PIXEL_BYTES = PNGU_MAX_PIXEL_BYTES
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [BYTE_W-1:0]      data_byte,

    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic      [BYTE_W-1:0]      pixel_byte,
    output logic                        row_end,
    output logic                        image_end,
    output logic                        bad_filter,

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int COL_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int TAP_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

    // configuration
    logic [BPP_W-1:0]       cfg_bpp_reg;
    logic [ROW_BYTES_W-1:0] cfg_row_bytes_reg;
    logic [ROW_COUNT_W-1:0] cfg_row_count_reg;

    // stream position
    logic [COL_W-1:0]       column_reg,  column_next;
    logic [ROW_COUNT_W-1:0] row_reg,     row_next;
    logic                   awaiting_reg, awaiting_next;
    filter_kind_t           kind_reg,    kind_next;
    logic                   bad_reg,     bad_next;

    // compute stage
    logic                   a_valid_reg;
    logic [BYTE_W-1:0]      a_byte_reg;
    logic [COL_W-1:0]       a_col_reg;
    logic                   a_first_row_reg;
    logic                   a_has_left_reg;
    logic [TAP_W-1:0]       a_tap_reg;
    filter_kind_t           a_kind_reg;
    logic                   a_bad_reg;
    logic                   a_last_col_reg;
    logic                   a_last_row_reg;

    logic [BYTE_W-1:0]      left_hist_reg   [MAX_PIXEL_BYTES];
    logic [BYTE_W-1:0]      upleft_hist_reg [MAX_PIXEL_BYTES];

    // output register
    logic                   out_valid_reg;
    logic [BYTE_W-1:0]      pixel_reg;
    logic                   row_end_reg;
    logic                   image_end_reg;
    logic                   out_bad_reg;

    logic                   in_fire;
    logic                   data_fire;
    logic                   a_adv;
    logic                   a_fire;

    logic [31:0]            bpp_wide;
    logic [31:0]            bpp_eff;
    logic [31:0]            rb_wide;
    logic [COL_W:0]         rb_eff;
    logic [ROW_COUNT_W-1:0] rc_eff;
    logic [COL_W:0]         col_plus;
    logic [ROW_COUNT_W:0]   row_plus;
    logic                   last_col;
    logic                   last_row;
    logic                   has_left;

    logic [BYTE_W-1:0]      mem_rdata;
    logic [BYTE_W-1:0]      pa;
    logic [BYTE_W-1:0]      pb;
    logic [BYTE_W-1:0]      pc;
    logic [BYTE_W:0]        avg_sum;
    logic [BYTE_W-1:0]      pred;
    logic [BYTE_W-1:0]      recon;

    assign cfg_ready = 1'b1;

    assign a_adv     = !out_valid_reg || !out_stall;
    assign a_fire    = a_valid_reg && a_adv;
    assign in_stall  = a_valid_reg && !a_adv;
    assign in_fire   = in_valid && !in_stall;
    assign data_fire = in_fire && !awaiting_reg;

    // effective limits, saturated to the supported range
    assign bpp_wide = 32'(cfg_bpp_reg);
    assign bpp_eff  = (bpp_wide == 32'd0) ? 32'd1 :
                      (bpp_wide > 32'(MAX_PIXEL_BYTES)) ? 32'(MAX_PIXEL_BYTES) : bpp_wide;
    assign rb_wide  = 32'(cfg_row_bytes_reg);
    assign rb_eff   = (rb_wide == 32'd0) ? (COL_W+1)'(1) :
                      (rb_wide > 32'(MAX_ROW_BYTES)) ? (COL_W+1)'(MAX_ROW_BYTES) :
                      (COL_W+1)'(rb_wide);
    assign rc_eff   = (cfg_row_count_reg == '0) ? ROW_COUNT_W'(1) : cfg_row_count_reg;

    assign col_plus = {1'b0, column_reg} + (COL_W+1)'(1);
    assign row_plus = {1'b0, row_reg} + (ROW_COUNT_W+1)'(1);
    assign last_col = col_plus >= rb_eff;
    assign last_row = row_plus >= {1'b0, rc_eff};
    assign has_left = 32'(column_reg) >= bpp_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_bpp_reg       <= BPP_W'(1);
            cfg_row_bytes_reg <= ROW_BYTES_W'(1);
            cfg_row_count_reg <= ROW_COUNT_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_BYTES_PER_PIXEL: cfg_bpp_reg       <= cfg_data[BPP_W-1:0];
                CFG_ROW_BYTES:       cfg_row_bytes_reg <= cfg_data[ROW_BYTES_W-1:0];
                CFG_ROW_COUNT:       cfg_row_count_reg <= cfg_data[ROW_COUNT_W-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        column_next   = column_reg;
        row_next      = row_reg;
        awaiting_next = awaiting_reg;
        kind_next     = kind_reg;
        bad_next      = bad_reg;
        if (in_fire)
        begin
            if (awaiting_reg)
            begin
                awaiting_next = 1'b0;
                if (data_byte > BYTE_W'(FILT_PAETH))
                begin
                    kind_next = FILT_NONE;
                    bad_next  = 1'b1;
                end
                else
                begin
                    kind_next = filter_kind_t'(data_byte[2:0]);
                    bad_next  = 1'b0;
                end
            end
            else if (last_col)
            begin
                column_next   = '0;
                awaiting_next = 1'b1;
                row_next      = last_row ? '0 : row_plus[ROW_COUNT_W-1:0];
            end
            else
            begin
                column_next = col_plus[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg   <= '0;
            row_reg      <= '0;
            awaiting_reg <= 1'b1;
            kind_reg     <= FILT_NONE;
            bad_reg      <= 1'b0;
            a_valid_reg  <= 1'b0;
        end
        else
        begin
            column_reg   <= column_next;
            row_reg      <= row_next;
            awaiting_reg <= awaiting_next;
            kind_reg     <= kind_next;
            bad_reg      <= bad_next;
            if (data_fire)
                a_valid_reg <= 1'b1;
            else if (a_adv)
                a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_fire)
        begin
            a_byte_reg      <= data_byte;
            a_col_reg       <= column_reg;
            a_first_row_reg <= (row_reg == '0);
            a_has_left_reg  <= has_left;
            a_tap_reg       <= TAP_W'(bpp_eff - 32'd1);
            a_kind_reg      <= kind_reg;
            a_bad_reg       <= bad_reg;
            a_last_col_reg  <= last_col;
            a_last_row_reg  <= last_row;
        end
    end

    // line store: read as the byte is taken, written back as it leaves the compute stage
    png_unf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_ROW_BYTES)
    ) u_line_store (
        .clk   (clk),
        .we    (a_fire),
        .waddr (a_col_reg),
        .wdata (recon),
        .re    (data_fire),
        .raddr (column_reg),
        .rdata (mem_rdata)
    );

    assign pa      = a_has_left_reg ? left_hist_reg[a_tap_reg] : '0;
    assign pb      = a_first_row_reg ? '0 : mem_rdata;
    assign pc      = (a_has_left_reg && !a_first_row_reg) ? upleft_hist_reg[a_tap_reg] : '0;
    assign avg_sum = {1'b0, pa} + {1'b0, pb};

    always_comb
    begin
        case (a_kind_reg)
            FILT_NONE:  pred = '0;
            FILT_SUB:   pred = pa;
            FILT_UP:    pred = pb;
            FILT_AVG:   pred = avg_sum[BYTE_W:1];
            FILT_PAETH: pred = paeth_pick(pa, pb, pc);
            default:    pred = '0;
        endcase
    end

    assign recon = a_byte_reg + pred;

    // newest first; the upper history takes the raw line-store word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_PIXEL_BYTES; i++)
            begin
                left_hist_reg[i]   <= '0;
                upleft_hist_reg[i] <= '0;
            end
        end
        else if (a_fire)
        begin
            left_hist_reg[0]   <= recon;
            upleft_hist_reg[0] <= mem_rdata;
            for (int i = 1; i < MAX_PIXEL_BYTES; i++)
            begin
                left_hist_reg[i]   <= left_hist_reg[i-1];
                upleft_hist_reg[i] <= upleft_hist_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (a_fire)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (a_fire)
        begin
            pixel_reg     <= recon;
            row_end_reg   <= a_last_col_reg;
            image_end_reg <= a_last_col_reg && a_last_row_reg;
            out_bad_reg   <= a_bad_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_byte = pixel_reg;
    assign row_end    = row_end_reg;
    assign image_end  = image_end_reg;
    assign bad_filter = out_bad_reg;

    // a data byte never reads the column still being written back
    assert property (@(posedge clk) disable iff (!rst_n)
        (a_fire && data_fire) |-> (a_col_reg != column_reg))
        else $error("line store read collides with write-back");

    assert property (@(posedge clk) disable iff (!rst_n)
        (column_reg != '0) |-> !awaiting_reg)
        else $error("filter byte expected mid-row");

    assert property (@(posedge clk) disable iff (!rst_n)
        a_fire |=> (out_valid_reg && pixel_reg == $past(recon)))
        else $error("result lost leaving the compute stage");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && image_end_reg) |-> row_end_reg)
        else $error("image end without row end");

endmodule

`default_nettype wire

FILE: sim/png_scanline_unfilter_core_tb.sv
`default_nettype none

module png_scanline_unfilter_core_tb;
    import png_unf_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_BYTES  = 1400;
    localparam int STEADY_BYTES  = 1100;
    localparam int SETTLE_CYCLES = 4;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED     = 2'd3;
    localparam logic [BYTE_W-1:0]      UNKNOWN_FILTER = 8'd5;
    localparam logic [BYTE_W-1:0]      MAX_FILTER     = 8'hFF;

    typedef struct packed {
        logic [BYTE_W-1:0] pixel;
        logic              row_end;
        logic              image_end;
        logic              bad;
    } pixel_word_t;

    // ------------------------------------------------------------------
    // scanline reconstruction predictor and expected-word store
    // ------------------------------------------------------------------
    class recon_scoreboard;
        logic [BPP_W-1:0]       bpp_reg;
        logic [ROW_BYTES_W-1:0] rb_reg;
        logic [ROW_COUNT_W-1:0] rc_reg;
        logic [BYTE_W-1:0]      line_store [PNGU_MAX_ROW_BYTES];
        logic [BYTE_W-1:0]      left_hist [8];
        logic [BYTE_W-1:0]      upper_hist [8];
        int                     column;
        int                     row;
        bit                     awaiting;
        filter_kind_t           kind;
        bit                     row_bad;
        pixel_word_t            expected_pixels [$];
        int                     errors;

        function new();
            bpp_reg  = 1;
            rb_reg   = 1;
            rc_reg   = 1;
            foreach (line_store[i]) line_store[i] = '0;
            foreach (left_hist[i]) left_hist[i] = '0;
            foreach (upper_hist[i]) upper_hist[i] = '0;
            column   = 0;
            row      = 0;
            awaiting = 1'b1;
            kind     = FILT_NONE;
            row_bad  = 1'b0;
            errors   = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_BYTES_PER_PIXEL: bpp_reg = data[BPP_W-1:0];
                CFG_ROW_BYTES:       rb_reg  = data[ROW_BYTES_W-1:0];
                CFG_ROW_COUNT:       rc_reg  = data[ROW_COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        function int paeth_nearest(int a, int b, int c);
            int p, da, db, dc;
            p  = a + b - c;
            da = (p > a) ? p - a : a - p;
            db = (p > b) ? p - b : b - p;
            dc = (p > c) ? p - c : c - p;
            if (da <= db && da <= dc)
                return a;
            else if (db <= dc)
                return b;
            else
                return c;
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        function void note_byte(logic [BYTE_W-1:0] x);
            int          bpp, rb, rc, col, a, b, c, up, sum;
            bit          first_row, has_left, last_col, last_row;
            pixel_word_t w;
            if (awaiting) begin
                if (x > 8'(FILT_PAETH)) begin
                    kind    = FILT_NONE;
                    row_bad = 1'b1;
                end
                else begin
                    kind    = filter_kind_t'(x[2:0]);
                    row_bad = 1'b0;
                end
                awaiting = 1'b0;
                return;
            end
            bpp = (bpp_reg < 1) ? 1 : ((bpp_reg > PNGU_MAX_PIXEL_BYTES) ?
                  PNGU_MAX_PIXEL_BYTES : int'(bpp_reg));
            rb  = (rb_reg < 1) ? 1 : ((rb_reg > PNGU_MAX_ROW_BYTES) ?
                  PNGU_MAX_ROW_BYTES : int'(rb_reg));
            rc  = (rc_reg < 1) ? 1 : int'(rc_reg);
            col = (column >= PNGU_MAX_ROW_BYTES) ? PNGU_MAX_ROW_BYTES - 1 : column;

            first_row = (row == 0);
            has_left  = (col >= bpp);
            up = line_store[col];
            a  = has_left ? left_hist[bpp-1] : 0;
            b  = first_row ? 0 : up;
            c  = (has_left && !first_row) ? upper_hist[bpp-1] : 0;

            case (kind)
                FILT_SUB:   sum = x + a;
                FILT_UP:    sum = x + b;
                FILT_AVG:   sum = x + ((a + b) >> 1);
                FILT_PAETH: sum = x + paeth_nearest(a, b, c);
                default:    sum = x;
            endcase

            w.pixel = sum[BYTE_W-1:0];
            line_store[col] = w.pixel;
            for (int i = 7; i > 0; i--) begin
                left_hist[i]  = left_hist[i-1];
                upper_hist[i] = upper_hist[i-1];
            end
            left_hist[0]  = w.pixel;
            upper_hist[0] = up[BYTE_W-1:0];

            last_col    = (column + 1 >= rb);
            last_row    = (row + 1 >= rc);
            w.row_end   = last_col;
            w.image_end = last_col && last_row;
            w.bad       = row_bad;
            expected_pixels.insert(expected_pixels.size(), w);

            if (last_col) begin
                column   = 0;
                awaiting = 1'b1;
                row      = last_row ? 0 : ((row + 1) & 16'hFFFF);
            end
            else begin
                column = column + 1;
            end
        endfunction

        function void flag(string field, int exp_val, int act_val);
            errors++;
            $error("%s: expected %0h, got %0h", field, exp_val, act_val);
        endfunction

        function void check_pixel(logic [BYTE_W-1:0] pix, logic re, logic ie, logic bf);
            pixel_word_t w;
            if (expected_pixels.size() == 0) begin
                flag("pixel_byte (no word expected)", -1, pix);
                return;
            end
            w = expected_pixels.pop_front();
            if (pix !== w.pixel)    flag("pixel_byte", w.pixel, pix);
            if (re !== w.row_end)   flag("row_end", w.row_end, re);
            if (ie !== w.image_end) flag("image_end", w.image_end, ie);
            if (bf !== w.bad)       flag("bad_filter", w.bad, bf);
        endfunction
    endclass

    // ------------------------------------------------------------------
    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [BYTE_W-1:0]      data_byte;
    logic                   out_valid;
    logic                   out_stall;
    logic [BYTE_W-1:0]      pixel_byte;
    logic                   row_end;
    logic                   image_end;
    logic                   bad_filter;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    recon_scoreboard sb;
    bit              steady;
    int              bytes_sent;
    int              idle_cycles;
    int              stall_left;
    bit              moved;

    png_scanline_unfilter_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel_byte (pixel_byte),
        .row_end    (row_end),
        .image_end  (image_end),
        .bad_filter (bad_filter),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #2 clk = ~clk;

    // receiver back-pressure in random bursts until steady is set
    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
        end
        else if (!steady && rst_n && $urandom_range(0, 4) == 0) begin
            out_stall  <= 1'b1;
            stall_left = $urandom_range(0, 2);
        end
        else begin
            out_stall <= 1'b0;
        end
    end

    // monitor and watchdog
    always @(posedge clk) begin
        if (rst_n) begin
            moved = 1'b0;
            if (out_valid && !out_stall) begin
                sb.check_pixel(pixel_byte, row_end, image_end, bad_filter);
                moved = 1'b1;
            end
            if (in_valid && !in_stall) begin
                sb.note_byte(data_byte);
                moved = 1'b1;
            end
            if (cfg_valid && cfg_ready) begin
                sb.write_reg(cfg_index, cfg_data);
                moved = 1'b1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("png_scanline_unfilter_core_tb: FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = (!steady && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
    endtask

    // drain the pipe before touching registers
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg_port(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [BYTE_W-1:0] pick_sample();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] pick_filter();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(UNKNOWN_FILTER, MAX_FILTER));
        return 8'($urandom_range(FILT_NONE, FILT_PAETH));
    endfunction

    task automatic send_row(input logic [BYTE_W-1:0] filt, input int n);
        send_byte(filt);
        repeat (n) send_byte(pick_sample());
    endtask

    // ------------------------------------------------------------------
    initial begin
        int base, sel, bpp_val, rb_val, rc_val, images;
        sb         = new();
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        data_byte  = '0;
        out_stall  = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_BYTES_PER_PIXEL;
        cfg_data   = '0;
        steady     = 1'b0;
        bytes_sent = 0;
        idle_cycles = 0;
        stall_left = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset geometry: one-byte rows, one-row images; unknown filters pass through
        send_byte(MAX_FILTER);
        send_byte(8'hFF);
        send_byte(UNKNOWN_FILTER);
        send_byte(8'h00);
        settle();

        // every filter once, each but None on a row with a previous row above it
        write_reg_port(CFG_BYTES_PER_PIXEL, 16'h0001);
        write_reg_port(CFG_ROW_BYTES, 16'h0002);
        write_reg_port(CFG_ROW_COUNT, 16'h0005);
        send_row(8'(FILT_NONE), 2);
        send_row(8'(FILT_SUB), 2);
        send_row(8'(FILT_UP), 2);
        send_row(8'(FILT_AVG), 2);
        send_row(8'(FILT_PAETH), 2);
        settle();

        // shrink row and image limits part way through
        write_reg_port(CFG_BYTES_PER_PIXEL, {12'($urandom), 4'd2});
        write_reg_port(CFG_ROW_BYTES, 16'h0006);
        write_reg_port(CFG_ROW_COUNT, 16'hFFFF);
        write_reg_port(CFG_UNUSED, 16'($urandom));
        send_row(8'(FILT_PAETH), 4);
        settle();
        write_reg_port(CFG_ROW_BYTES, {2'b11, 14'd2});
        send_byte(pick_sample());
        send_row(8'(FILT_UP), 2);
        settle();
        write_reg_port(CFG_ROW_COUNT, 16'h0000);
        send_row(8'(FILT_AVG), 2);
        settle();

        // widest pixels, two rows so the line store is read back
        write_reg_port(CFG_BYTES_PER_PIXEL, 16'hFFFF);
        write_reg_port(CFG_ROW_BYTES, 16'hC020);
        write_reg_port(CFG_ROW_COUNT, 16'h0002);
        send_row(8'(FILT_SUB), 32);
        send_row(8'(FILT_PAETH), 32);
        settle();

        base = bytes_sent;
        while (bytes_sent - base < RANDOM_BYTES) begin
            sel     = $urandom_range(0, 9);
            bpp_val = (sel == 0) ? 0 : ((sel == 1) ? $urandom_range(9, 15) :
                      $urandom_range(1, PNGU_MAX_PIXEL_BYTES));
            sel     = $urandom_range(0, 9);
            rb_val  = (sel == 0) ? 0 : ((sel == 1) ? $urandom_range(25, 64) :
                      $urandom_range(1, 24));
            rc_val  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);

            write_reg_port(CFG_BYTES_PER_PIXEL, {12'($urandom), 4'(bpp_val)});
            write_reg_port(CFG_ROW_BYTES, {2'($urandom), 14'(rb_val)});
            write_reg_port(CFG_ROW_COUNT, 16'(rc_val));
            if ($urandom_range(0, 3) == 0)
                write_reg_port(CFG_UNUSED, 16'($urandom));

            if (rb_val == 0) rb_val = 1;
            if (rc_val == 0) rc_val = 1;
            images = $urandom_range(1, 2);
            repeat (images * rc_val) send_row(pick_filter(), rb_val);
            if (bytes_sent - base >= STEADY_BYTES)
                steady = 1'b1;
            settle();
        end

        steady = 1'b1;
        while (sb.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("png_scanline_unfilter_core_tb: PASS");
        else
            $display("png_scanline_unfilter_core_tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
sv/png_unf_pkg.sv
sv/png_unf_ram.sv
sv/png_scanline_unfilter_core.sv
sim/png_scanline_unfilter_core_tb.sv
